// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the register link master RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/urlm_pkg.sv =====
// Types and constants of the UART register link master.
// No dependencies; imported by urlm_core, urlm_out and the top level.
`default_nettype none

package urlm_pkg;

  localparam int unsigned REPLY_BYTES = 8;
  localparam int unsigned FRAME_BYTES = 7;
  localparam int unsigned IDX_W       = $clog2(REPLY_BYTES);
  localparam int unsigned BEAT_W      = $clog2(FRAME_BYTES);
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [7:0] TX_HEAD0   = 8'hcf;
  localparam logic [7:0] TX_HEAD1   = 8'h55;
  localparam logic [7:0] RX_HEAD0   = 8'hce;
  localparam logic [7:0] RX_HEAD1   = 8'haa;
  localparam logic [7:0] RX_STAT_OK = 8'h01;

  localparam logic [3:0] CNT_MAX   = 4'hf;
  localparam logic [3:0] RST_LIMIT = 4'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SENDS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_READS = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RX_BYTE = 2'd2,
    OP_TIMEOUT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_REPLY = 3'd1,
    ST_BAD_HEAD = 3'd2,
    ST_BAD_TYPE = 3'd3,
    ST_BAD_ADDR = 3'd4,
    ST_FAIL     = 3'd5,
    ST_BAD_SUM  = 3'd6
  } status_t;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_WAIT = 1'b1
  } phase_t;

  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_FRAME = 2'd1,
    RES_DONE  = 2'd2
  } res_t;

  // What one request leaves for the output side: a frame, a completion or none.
  typedef struct packed {
    res_t        res;
    logic        is_read;
    logic [7:0]  addr;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  sum;
    logic        success;
    logic [15:0] rd_data;
    status_t     status;
  } desc_t;

  function automatic logic [3:0] sat_inc(input logic [3:0] x);
    sat_inc = (x == CNT_MAX) ? x : x + 4'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/urlm_core.sv =====
// Command and reply state of the register link master: one request per cycle while accept is high.
// Depends on urlm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module urlm_core
  import urlm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [3:0]           cfg_data,
  input  wire logic                 accept,
  input  wire logic [1:0]           op,
  input  wire logic [7:0]           reg_addr,
  input  wire logic [15:0]          wr_data,
  input  wire logic [7:0]           rx_byte,
  output desc_t                     desc
);

  logic [3:0]       max_sends_r, max_reads_r;
  phase_t           phase_r, phase_nxt;
  logic             is_read_r, is_read_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [15:0]      value_r, value_nxt;
  logic [3:0]       sends_r, sends_nxt;
  logic [3:0]       reads_r, reads_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [7:0]       high_r, high_nxt;
  status_t          err_r, err_nxt;

  logic [3:0] lim_sends, lim_reads, reads_inc;
  status_t    code, err_new, fail_st;
  logic       do_frame, do_fail, do_ok, retry;
  op_t        op_e;
  logic       idle_clean;

  assign op_e      = op_t'(op);
  assign lim_sends = (max_sends_r == 4'd0) ? 4'd1 : max_sends_r;
  assign lim_reads = (max_reads_r == 4'd0) ? 4'd1 : max_reads_r;
  assign reads_inc = sat_inc(reads_r);

  // Check of the current reply byte against its expected value.
  always_comb begin
    code = ST_OK;
    unique case (idx_r)
      3'd0: if (rx_byte != RX_HEAD0) code = ST_BAD_HEAD;
      3'd1: if (rx_byte != RX_HEAD1) code = ST_BAD_HEAD;
      3'd2: if (rx_byte != {7'd0, is_read_r}) code = ST_BAD_TYPE;
      3'd3: if (rx_byte != addr_r) code = ST_BAD_ADDR;
      3'd4: if (rx_byte != RX_STAT_OK) code = ST_FAIL;
      3'd5, 3'd6: code = ST_OK;
      default: if (rx_byte != sum_r) code = ST_BAD_SUM;
    endcase
    err_new = (err_r != ST_OK) ? err_r : code;
  end

  always_comb begin
    phase_nxt   = phase_r;
    is_read_nxt = is_read_r;
    addr_nxt    = addr_r;
    value_nxt   = value_r;
    sends_nxt   = sends_r;
    reads_nxt   = reads_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    err_nxt     = err_r;
    do_frame    = 1'b0;
    do_fail     = 1'b0;
    do_ok       = 1'b0;
    retry       = 1'b0;
    fail_st     = ST_NO_REPLY;

    if (accept) begin
      case (op_e)
        OP_WRITE, OP_READ: begin
          if (phase_r == PH_IDLE) begin
            is_read_nxt = op[0];
            addr_nxt    = reg_addr;
            value_nxt   = op[0] ? 16'd0 : wr_data;
            phase_nxt   = PH_WAIT;
            sends_nxt   = 4'd1;
            reads_nxt   = 4'd0;
            do_frame    = 1'b1;
          end
        end
        OP_TIMEOUT: begin
          if (phase_r == PH_WAIT) begin
            if (reads_inc < lim_reads) begin
              reads_nxt = reads_inc;
            end else begin
              retry   = 1'b1;
              fail_st = ST_NO_REPLY;
            end
          end
        end
        default: begin
          if (phase_r == PH_WAIT) begin
            if (idx_r == 3'd5) low_nxt = rx_byte;
            if (idx_r == 3'd6) high_nxt = rx_byte;
            if (idx_r >= 3'd2 && idx_r <= 3'd6) sum_nxt = sum_r + rx_byte;
            err_nxt = err_new;
            if (idx_r != IDX_W'(REPLY_BYTES - 1)) begin
              idx_nxt = idx_r + 1'b1;
            end else if (err_new != ST_OK) begin
              retry   = 1'b1;
              fail_st = err_new;
            end else begin
              do_ok = 1'b1;
            end
          end
        end
      endcase

      if (retry) begin
        if (sends_r < lim_sends) begin
          sends_nxt = sat_inc(sends_r);
          reads_nxt = 4'd0;
          do_frame  = 1'b1;
        end else begin
          do_fail = 1'b1;
        end
      end
      if (do_fail || do_ok) begin
        phase_nxt = PH_IDLE;
        sends_nxt = 4'd0;
        reads_nxt = 4'd0;
      end
      // Any frame, completion or timeout starts a fresh reply.
      if (do_frame || do_fail || do_ok || (op_e == OP_TIMEOUT && phase_r == PH_WAIT)) begin
        idx_nxt  = '0;
        sum_nxt  = 8'd0;
        low_nxt  = 8'd0;
        high_nxt = 8'd0;
        err_nxt  = ST_OK;
      end
    end
  end

  always_comb begin
    desc.res     = do_frame ? RES_FRAME : ((do_fail || do_ok) ? RES_DONE : RES_NONE);
    desc.is_read = is_read_nxt;
    desc.addr    = addr_nxt;
    desc.lo      = value_nxt[7:0];
    desc.hi      = value_nxt[15:8];
    desc.sum     = {7'd0, is_read_nxt} + addr_nxt + value_nxt[7:0] + value_nxt[15:8];
    desc.success = do_ok;
    desc.rd_data = (do_ok && is_read_r) ? {high_r, low_r} : 16'd0;
    desc.status  = do_ok ? ST_OK : fail_st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sends_r <= RST_LIMIT;
      max_reads_r <= RST_LIMIT;
      phase_r     <= PH_IDLE;
      is_read_r   <= 1'b0;
      addr_r      <= 8'd0;
      value_r     <= 16'd0;
      sends_r     <= 4'd0;
      reads_r     <= 4'd0;
      idx_r       <= '0;
      sum_r       <= 8'd0;
      low_r       <= 8'd0;
      high_r      <= 8'd0;
      err_r       <= ST_OK;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_SENDS: max_sends_r <= cfg_data;
          default:       max_reads_r <= cfg_data;
        endcase
      end
      phase_r   <= phase_nxt;
      is_read_r <= is_read_nxt;
      addr_r    <= addr_nxt;
      value_r   <= value_nxt;
      sends_r   <= sends_nxt;
      reads_r   <= reads_nxt;
      idx_r     <= idx_nxt;
      sum_r     <= sum_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      err_r     <= err_nxt;
    end
  end

  assign idle_clean = sends_r == 4'd0 && reads_r == 4'd0 && idx_r == '0 && err_r == ST_OK;

  // Limits may be lowered mid-command, so the frame count is checked only as nonzero, not against its limit.
  `ASSERT_IMPL(a_idle_clear, clk, rst_n, phase_r == PH_IDLE, idle_clean, "stale state in idle")
  `ASSERT_IMPL(a_wait_sent, clk, rst_n, phase_r == PH_WAIT, sends_r != 4'd0, "wait, no frame")

endmodule

`default_nettype wire

// ===== rtl/urlm_out.sv =====
// Result stage: holds one frame or completion and sends a frame one byte per output transfer.
// Depends on urlm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module urlm_out
  import urlm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  wire desc_t        desc_in,
  output logic              take,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_kind,
  output logic [7:0]        out_tx_byte,
  output logic              out_last,
  output logic              out_success,
  output logic [15:0]       out_rd_data,
  output logic [2:0]        out_status
);

  logic              valid_r;
  logic [BEAT_W-1:0] beat_r;
  desc_t             desc_r;
  logic              done;
  logic              step;

  assign done      = (desc_r.res == RES_DONE);
  assign out_valid = valid_r;
  assign out_kind  = done;
  assign out_last  = done || (beat_r == BEAT_W'(FRAME_BYTES - 1));
  assign take      = !valid_r || (out_ready && out_last);
  assign step      = valid_r && out_ready && !out_last;

  assign out_success = done ? desc_r.success : 1'b0;
  assign out_rd_data = done ? desc_r.rd_data : 16'd0;
  assign out_status  = done ? desc_r.status : ST_OK;

  always_comb begin
    out_tx_byte = 8'd0;
    if (!done) begin
      case (beat_r)
        3'd0:    out_tx_byte = TX_HEAD0;
        3'd1:    out_tx_byte = TX_HEAD1;
        3'd2:    out_tx_byte = {7'd0, desc_r.is_read};
        3'd3:    out_tx_byte = desc_r.addr;
        3'd4:    out_tx_byte = desc_r.lo;
        3'd5:    out_tx_byte = desc_r.hi;
        default: out_tx_byte = desc_r.sum;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      beat_r  <= '0;
    end else if (valid_r && out_ready) begin
      if (out_last) begin
        valid_r <= 1'b0;
        beat_r  <= '0;
      end else begin
        beat_r <= beat_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) desc_r <= desc_in;
  end

  `ASSERT_IMPL(a_done_single, clk, rst_n, valid_r && done, beat_r == '0, "late completion beat")
  `ASSERT_NEXT(a_beat_step, clk, rst_n, step, valid_r && beat_r == $past(beat_r) + 1'b1, "beat stuck")

endmodule

`default_nettype wire

// ===== rtl/uart_register_link_master_unit.sv =====
// UART register link master: channels, command/reply state and result stage.
// Depends on urlm_pkg, urlm_core and urlm_out.
//
// Use: the in_ channel carries write and read commands, received link bytes
// and reply-window timeouts. A command taken in idle gives a 7-byte frame on
// the out_ channel (out_kind 0, one byte per transfer, out_last on the
// checksum); a finished command gives one completion (out_kind 1) with
// success, status and, for a read, the data. Timeouts that stay under
// max_reads and reply bytes before the eighth give no result.
// Latency: an accepted request is registered and its first result is shown
// the next cycle. Throughput: one request per cycle while it gives no result
// or a completion and out_ready is high; a frame holds the result stage until
// its 7 bytes are taken, one byte per transfer, and in_ready is low until its
// last byte is taken (in_ready rises in the cycle that byte goes).
// A stalled receiver (out_ready low) holds the current result and, once the
// stage is full, in_ready. cfg_ready is always high; registers hold limits.
// Reset (rst_n low, synchronous) empties the result stage, returns to idle
// and sets both limits to 3. No clearing pass is needed.
`default_nettype none

module uart_register_link_master_unit
  import urlm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [3:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_op,
  input  wire logic [7:0]           in_reg_addr,
  input  wire logic [15:0]          in_wr_data,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_kind,
  output logic [7:0]                out_tx_byte,
  output logic                      out_last,
  output logic                      out_success,
  output logic [15:0]               out_rd_data,
  output logic [2:0]                out_status
);

  desc_t desc;
  logic  take, accept, load;

  assign cfg_ready = 1'b1;
  assign in_ready  = take;
  assign accept    = in_valid && take;
  assign load      = accept && (desc.res != RES_NONE);

  urlm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (in_op),
    .reg_addr  (in_reg_addr),
    .wr_data   (in_wr_data),
    .rx_byte   (in_rx_byte),
    .desc      (desc)
  );

  urlm_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .desc_in     (desc),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_tx_byte (out_tx_byte),
    .out_last    (out_last),
    .out_success (out_success),
    .out_rd_data (out_rd_data),
    .out_status  (out_status)
  );

endmodule

`default_nettype wire
